/* rtl/cna_pkg.sv */
// Package with the shared types, codes and constants of the chord note arpeggiator.
`timescale 1ns / 1ps

package cna_pkg;

    localparam int MAX_NOTES = 16;
    localparam int IDX_W     = $clog2(MAX_NOTES);
    localparam int CNT_W     = IDX_W + 1;

    localparam int PITCH_W   = 7;
    localparam int VEL_W     = 7;
    localparam int LIMIT_W   = 8;
    localparam int SIZE_W    = 5;
    localparam int NOTES_W   = 63;
    localparam int SLOT_W    = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = NOTES_W;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTES_LO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTES_HI = 2'd2;

    localparam logic [1:0] CMD_ON    = 2'd0;
    localparam logic [1:0] CMD_OFF   = 2'd1;
    localparam logic [1:0] CMD_RESET = 2'd2;

    localparam int LFSR_W     = 16;
    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
    localparam int DIV_BITS   = 4;
    localparam int DIV_CYC    = LFSR_W / DIV_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_CYC);

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        MODE_FIRST  = 2'd0,
        MODE_LAST   = 2'd1,
        MODE_RANDOM = 2'd2,
        MODE_ALL    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        OP_ON,
        OP_OFF,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op                op;
        t_mode              mode;
        logic [VEL_W-1:0]   vel;
        logic [LIMIT_W-1:0] limit;
    } t_job;

    function automatic logic [CNT_W-1:0] popcount(input logic [MAX_NOTES-1:0] v);
        logic [CNT_W-1:0] c;
        c = '0;
        for (int i = 0; i < MAX_NOTES; i++) begin
            c = c + CNT_W'(v[i]);
        end
        return c;
    endfunction

endpackage

/* rtl/cna_if.sv */
// Handshake interfaces for the command items and the note result items.
`timescale 1ns / 1ps

interface cna_cmd_if;
    import cna_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [1:0]         mode;
    logic [VEL_W-1:0]   velocity;
    logic [LIMIT_W-1:0] count;

    modport source (output valid, command, mode, velocity, count, input ready);
    modport sink (input valid, command, mode, velocity, count, output ready);
endinterface

interface cna_note_if;
    import cna_pkg::*;

    logic               valid;
    logic               ready;
    logic [PITCH_W-1:0] pitch;
    logic [VEL_W-1:0]   note_velocity;
    logic [SIZE_W-1:0]  active_count;
    logic               last_of_run;

    modport source (output valid, pitch, note_velocity, active_count, last_of_run,
                    input ready);
    modport sink (input valid, pitch, note_velocity, active_count, last_of_run,
                  output ready);
endinterface

/* rtl/cna_front.sv */
// Front end that accepts command items and turns them into queued jobs.
`timescale 1ns / 1ps

module cna_front (
    cna_cmd_if.sink          i_cmd,
    input  logic             i_queue_full,
    output logic             o_push,
    output cna_pkg::t_job    o_job
);
    import cna_pkg::*;

    logic known;

    assign i_cmd.ready = !i_queue_full;

    always_comb begin
        known       = 1'b1;
        o_job.op    = OP_CLEAR;
        o_job.mode  = t_mode'(i_cmd.mode);
        o_job.vel   = i_cmd.velocity;
        o_job.limit = (t_mode'(i_cmd.mode) == MODE_ALL) ? LIMIT_W'(MAX_NOTES) : i_cmd.count;
        case (i_cmd.command)
            CMD_ON: begin
                o_job.op = OP_ON;
            end
            CMD_OFF: begin
                o_job.op  = OP_OFF;
                o_job.vel = '0;
            end
            CMD_RESET: begin
                o_job.op = OP_CLEAR;
            end
            default: begin
                known = 1'b0;
            end
        endcase
    end

    // Items with the unused command code are taken and dropped.
    assign o_push = i_cmd.valid && !i_queue_full && known;

endmodule

/* rtl/cna_queue.sv */
// Short job queue between the front end and the note engine.
`timescale 1ns / 1ps

module cna_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cna_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_valid,
    output cna_pkg::t_job o_job,
    input  logic          i_pop
);
    import cna_pkg::*;

    t_job                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_PTR_W:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* rtl/cna_back.sv */
// Note engine that holds the chord, the note flags and the random source and emits note items.
`timescale 1ns / 1ps

module cna_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cna_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [cna_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_job_valid,
    input  cna_pkg::t_job                   i_job,
    output logic                            o_job_pop,
    cna_note_if.source                      o_note
);
    import cna_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_SEL,
        S_EMIT
    } t_state;

    t_state               r_state;
    logic [MAX_NOTES-1:0] r_flags;
    logic [CNT_W-1:0]     r_active;
    logic [LFSR_W-1:0]    r_lfsr;
    logic [SIZE_W-1:0]    r_size;
    logic [NOTES_W-1:0]   r_notes_lo;
    logic [NOTES_W-1:0]   r_notes_hi;

    logic                 r_target;
    t_mode                r_mode;
    logic [VEL_W-1:0]     r_vel;
    logic [LIMIT_W-1:0]   r_limit;
    logic [CNT_W-1:0]     r_produced;
    logic [MAX_NOTES-1:0] r_mask;
    logic [CNT_W-1:0]     r_cand_cnt;
    logic [IDX_W-1:0]     r_idx;
    logic [IDX_W-1:0]     r_rem;
    logic [LFSR_W-1:0]    r_div_sh;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    logic                 r_out_valid;
    logic [PITCH_W-1:0]   r_out_pitch;
    logic [VEL_W-1:0]     r_out_vel;
    logic [SIZE_W-1:0]    r_out_active;
    logic                 r_out_last;

    logic [MAX_NOTES-1:0] chord_mask;
    logic [MAX_NOTES-1:0] cand_mask;
    logic [CNT_W-1:0]     cand_cnt;
    logic [IDX_W-1:0]     first_idx;
    logic [IDX_W-1:0]     last_idx;
    logic [IDX_W-1:0]     kth_idx;
    logic [LFSR_W-1:0]    lfsr_nx;
    logic [IDX_W-1:0]     n_rem;
    logic [LFSR_W-1:0]    n_div_sh;
    logic [CNT_W-1:0]     n_active;
    logic [CNT_W-1:0]     produced_inc;
    logic                 is_last;
    logic                 out_free;
    logic                 emit_now;
    logic [PITCH_W-1:0]   emit_pitch;
    logic [SIZE_W-1:0]    cfg_size;

    always_comb begin
        for (int i = 0; i < MAX_NOTES; i++) begin
            chord_mask[i] = (SIZE_W'(i) < r_size);
            cand_mask[i]  = chord_mask[i] && (r_flags[i] != r_target);
        end
        cand_cnt = popcount(cand_mask);
    end

    always_comb begin
        first_idx = '0;
        last_idx  = '0;
        for (int i = MAX_NOTES - 1; i >= 0; i--) begin
            if (cand_mask[i]) begin
                first_idx = IDX_W'(i);
            end
        end
        for (int i = 0; i < MAX_NOTES; i++) begin
            if (cand_mask[i]) begin
                last_idx = IDX_W'(i);
            end
        end
    end

    // The chosen candidate is the set bit of the mask with r_rem set bits below it.
    always_comb begin
        logic [MAX_NOTES-1:0] below;
        kth_idx = '0;
        for (int i = 0; i < MAX_NOTES; i++) begin
            below = r_mask & ((MAX_NOTES'(1) << i) - MAX_NOTES'(1));
            if (r_mask[i] && (popcount(below) == CNT_W'(r_rem))) begin
                kth_idx = IDX_W'(i);
            end
        end
    end

    assign lfsr_nx = {r_lfsr[0] ^ r_lfsr[2] ^ r_lfsr[3] ^ r_lfsr[5], r_lfsr[LFSR_W-1:1]};

    always_comb begin
        logic [IDX_W:0] part;
        n_rem    = r_rem;
        n_div_sh = r_div_sh;
        for (int b = 0; b < DIV_BITS; b++) begin
            part     = {n_rem, n_div_sh[LFSR_W-1]};
            n_div_sh = {n_div_sh[LFSR_W-2:0], 1'b0};
            if (part >= r_cand_cnt) begin
                part = part - r_cand_cnt;
            end
            n_rem = part[IDX_W-1:0];
        end
    end

    always_comb begin
        if (r_target) begin
            n_active = r_active + 1'b1;
        end else if (r_active != '0) begin
            n_active = r_active - 1'b1;
        end else begin
            n_active = r_active;
        end
    end

    assign produced_inc = r_produced + 1'b1;
    assign is_last      = (r_cand_cnt == CNT_W'(1))
                       || ({{(LIMIT_W - CNT_W){1'b0}}, produced_inc} == r_limit);
    assign out_free     = !r_out_valid || o_note.ready;
    assign emit_now     = (r_state == S_EMIT) && out_free;
    assign emit_pitch   = r_idx[IDX_W-1] ? r_notes_hi[{r_idx[IDX_W-2:0], 3'b000} +: PITCH_W]
                                         : r_notes_lo[{r_idx[IDX_W-2:0], 3'b000} +: PITCH_W];
    assign cfg_size     = (i_cfg_data[SIZE_W-1:0] > SIZE_W'(MAX_NOTES)) ? SIZE_W'(MAX_NOTES)
                                                                        : i_cfg_data[SIZE_W-1:0];
    assign o_job_pop    = (r_state == S_IDLE) && i_job_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_flags     <= '0;
            r_active    <= '0;
            r_lfsr      <= LFSR_SEED;
            r_size      <= '0;
            r_notes_lo  <= '0;
            r_notes_hi  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit_now) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_note.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        case (i_job.op)
                            OP_CLEAR: begin
                                r_flags  <= '0;
                                r_active <= '0;
                            end
                            OP_ON, OP_OFF: begin
                                if (r_size != '0) begin
                                    r_target   <= (i_job.op == OP_ON);
                                    r_mode     <= i_job.mode;
                                    r_vel      <= i_job.vel;
                                    r_limit    <= i_job.limit;
                                    r_produced <= '0;
                                    r_state    <= S_SCAN;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_mask     <= cand_mask;
                    r_cand_cnt <= cand_cnt;
                    if ((cand_cnt == '0)
                        || ({{(LIMIT_W - CNT_W){1'b0}}, r_produced} == r_limit)) begin
                        r_state <= S_IDLE;
                    end else begin
                        case (r_mode)
                            MODE_LAST: begin
                                r_idx   <= last_idx;
                                r_state <= S_EMIT;
                            end
                            MODE_RANDOM: begin
                                r_lfsr    <= lfsr_nx;
                                r_div_sh  <= lfsr_nx;
                                r_rem     <= '0;
                                r_div_cnt <= '0;
                                r_state   <= S_DIV;
                            end
                            default: begin
                                r_idx   <= first_idx;
                                r_state <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    r_rem     <= n_rem;
                    r_div_sh  <= n_div_sh;
                    r_div_cnt <= r_div_cnt + 1'b1;
                    if (r_div_cnt == DIV_CNT_W'(DIV_CYC - 1)) begin
                        r_state <= S_SEL;
                    end
                end
                S_SEL: begin
                    r_idx   <= kth_idx;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_pitch    <= emit_pitch;
                        r_out_vel      <= r_vel;
                        r_out_active   <= SIZE_W'(n_active);
                        r_out_last     <= is_last;
                        r_flags[r_idx] <= r_target;
                        r_active       <= n_active;
                        r_produced     <= produced_inc;
                        r_state        <= is_last ? S_IDLE : S_SCAN;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SIZE: begin
                        r_size   <= cfg_size;
                        r_flags  <= '0;
                        r_active <= '0;
                    end
                    CFG_NOTES_LO: begin
                        r_notes_lo <= i_cfg_data;
                    end
                    CFG_NOTES_HI: begin
                        r_notes_hi <= i_cfg_data;
                    end
                    default: begin
                        r_size <= r_size;
                    end
                endcase
            end
        end
    end

    assign o_note.valid         = r_out_valid;
    assign o_note.pitch         = r_out_pitch;
    assign o_note.note_velocity = r_out_vel;
    assign o_note.active_count  = r_out_active;
    assign o_note.last_of_run   = r_out_last;

    a_active_matches_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_flags) == 32'(r_active))
        else $error("Active note count differs from the number of set flags.");

    a_flags_inside_chord: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_flags & ~chord_mask) == '0)
        else $error("A flag is set outside the chord.");

    a_emit_is_candidate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> r_mask[r_idx])
        else $error("The chosen note is not a candidate.");

    a_rem_below_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV || r_state == S_SEL) |-> (CNT_W'(r_rem) < r_cand_cnt))
        else $error("Random remainder is not below the candidate count.");

endmodule

/* rtl/chord_note_arpeggiator_top.sv */
// Top level of the chord note arpeggiator: front end, job queue and note engine.
//
//   Channel   Dir   Handshake          Payload
//   i_cmd     in    valid/ready        command, mode, velocity, count
//   o_note    out   valid/ready        pitch, note_velocity, active_count, last_of_run
//   cfg       in    i_cfg_we           i_cfg_idx, i_cfg_data
//
// A command is queued in a two-entry job queue and popped by the engine while it is idle. First, last
// and all modes pass through the scan and emit states for each note; random mode adds the divide and
// select states, the divide state running the four-bit-per-cycle remainder unit. A reset command clears the flags.
// Reset is synchronous, clears the flags and the chord registers and reloads the random seed.
// The output register lets the engine run ahead by one note while the sink stalls.
`timescale 1ns / 1ps

module chord_note_arpeggiator_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    cna_cmd_if.sink                         i_cmd,
    cna_note_if.source                      o_note,
    input  logic                            i_cfg_we,
    input  logic [cna_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [cna_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import cna_pkg::*;

    logic queue_full;
    logic queue_push;
    logic queue_valid;
    logic queue_pop;
    t_job front_job;
    t_job queue_job;

    cna_front u_front (
        .i_cmd        (i_cmd),
        .i_queue_full (queue_full),
        .o_push       (queue_push),
        .o_job        (front_job)
    );

    cna_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (queue_push),
        .i_job   (front_job),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_job   (queue_job),
        .i_pop   (queue_pop)
    );

    cna_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_job_valid (queue_valid),
        .i_job       (queue_job),
        .o_job_pop   (queue_pop),
        .o_note      (o_note)
    );

endmodule
